// File: sv/tlics_pkg.sv
// ----------------------------------------------------------------------------
// tlics_pkg
// Shared types and constants of the two-level inverse CDF sampler: payload
// structs, operation and register codes, sequencer states and the request and
// response bundles of the interpolation unit.
// ----------------------------------------------------------------------------
package tlics_pkg;

    // Operation codes carried by an input transaction.
    localparam logic [1:0] OP_WR_COS   = 2'd0;
    localparam logic [1:0] OP_WR_EGRID = 2'd1;
    localparam logic [1:0] OP_WR_ECDF  = 2'd2;
    localparam logic [1:0] OP_SAMPLE   = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] REG_COS_POINTS    = 2'd0;
    localparam logic [1:0] REG_ENERGY_POINTS = 2'd1;
    localparam logic [1:0] REG_TABLES_READY  = 2'd2;
    localparam logic [1:0] REG_MIN_ENERGY    = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [7:0]  COS_POINTS_RST    = 8'd120;
    localparam logic [8:0]  ENERGY_POINTS_RST = 9'd200;
    localparam logic [31:0] MIN_ENERGY_RST    = 32'd6554;

    // Fixed-point one in UQ1.32 and UQ1.16.
    localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;
    localparam logic [16:0] ONE_Q16 = 17'h1_0000;

    typedef struct packed {
        logic [1:0]  operation;
        logic [6:0]  cos_index;
        logic [7:0]  energy_index;
        logic [32:0] cdf_value;
        logic [31:0] grid_value;
        logic [31:0] rand_cos;
        logic [31:0] rand_energy;
    } in_item_t;

    typedef struct packed {
        logic [31:0] energy;
        logic [16:0] cos_theta;
        logic        fallback;
    } out_item_t;

    // Request to the shared interpolation unit.
    typedef struct packed {
        logic        start;
        logic [32:0] c0;
        logic [32:0] c1;
        logic [31:0] v0;
        logic [31:0] v1;
        logic [31:0] r;
    } interp_req_t;

    // Response of the shared interpolation unit.
    typedef struct packed {
        logic        done;
        logic [31:0] value;
    } interp_rsp_t;

    typedef enum logic [1:0] {
        IP_IDLE,
        IP_DIV,
        IP_MUL,
        IP_FIN
    } interp_state_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WR,
        ST_CS_ADDR,
        ST_CS_CMP,
        ST_CL_ADDR,
        ST_CH_ADDR,
        ST_CH_DATA,
        ST_CI_WAIT,
        ST_ES_ADDR,
        ST_ES_CMP,
        ST_EL_ADDR,
        ST_EH_ADDR,
        ST_EH_DATA,
        ST_EI_WAIT,
        ST_OUT
    } seq_state_t;

endpackage

// File: sv/tlics_ram.sv
// ----------------------------------------------------------------------------
// tlics_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module tlics_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/tlics_interp.sv
// ----------------------------------------------------------------------------
// tlics_interp
// Shared interpolation unit: a bit-serial restoring divider forms the
// saturated fraction alpha, then one 32x32 multiplier scales the grid step.
// ----------------------------------------------------------------------------
module tlics_interp (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  tlics_pkg::interp_req_t req,
    output tlics_pkg::interp_rsp_t rsp
);

    tlics_pkg::interp_state_t state_reg, state_next;

    logic [31:0] q_reg, q_next;
    logic [32:0] rem_reg, rem_next;
    logic [32:0] dv_reg, dv_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        sat_reg, sat_next;
    logic [31:0] v0_reg, v0_next;
    logic [31:0] v1_reg, v1_next;
    logic [63:0] prod_reg, prod_next;

    logic        r_le_c0;
    logic [31:0] diff;
    logic [32:0] dv_start;
    logic [33:0] rem2;
    logic        rem_ge;
    logic        up;
    logic [31:0] mag;
    logic [31:0] step;

    // Operand preparation at start and one divider step.
    always_comb begin
        r_le_c0  = {1'b0, req.r} <= req.c0;
        diff     = req.r - req.c0[31:0];
        dv_start = (req.c1 > req.c0) ? (req.c1 - req.c0) : tlics_pkg::ONE_Q32;
        rem2     = {rem_reg, 1'b0};
        rem_ge   = rem2 >= {1'b0, dv_reg};
        up       = v1_reg >= v0_reg;
        mag      = up ? (v1_reg - v0_reg) : (v0_reg - v1_reg);
        step     = sat_reg ? mag : prod_reg[63:32];
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tlics_pkg::IP_IDLE: begin
                if (req.start) begin
                    if (r_le_c0 || ({1'b0, diff} >= dv_start)) begin
                        state_next = tlics_pkg::IP_MUL;
                    end else begin
                        state_next = tlics_pkg::IP_DIV;
                    end
                end
            end
            tlics_pkg::IP_DIV: begin
                if (cnt_reg == 5'd31) begin
                    state_next = tlics_pkg::IP_MUL;
                end
            end
            tlics_pkg::IP_MUL: state_next = tlics_pkg::IP_FIN;
            tlics_pkg::IP_FIN: state_next = tlics_pkg::IP_IDLE;
            default:           state_next = tlics_pkg::IP_IDLE;
        endcase
    end

    // Datapath register updates.
    always_comb begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        dv_next   = dv_reg;
        cnt_next  = cnt_reg;
        sat_next  = sat_reg;
        v0_next   = v0_reg;
        v1_next   = v1_reg;
        prod_next = prod_reg;
        case (state_reg)
            tlics_pkg::IP_IDLE: begin
                if (req.start) begin
                    v0_next  = req.v0;
                    v1_next  = req.v1;
                    q_next   = '0;
                    rem_next = {1'b0, diff};
                    dv_next  = dv_start;
                    cnt_next = '0;
                    sat_next = !r_le_c0 && ({1'b0, diff} >= dv_start);
                end
            end
            tlics_pkg::IP_DIV: begin
                rem_next = rem_ge ? 33'(rem2 - {1'b0, dv_reg}) : rem2[32:0];
                q_next   = {q_reg[30:0], rem_ge};
                cnt_next = cnt_reg + 5'd1;
            end
            tlics_pkg::IP_MUL: begin
                prod_next = q_reg * mag;
            end
            default: begin
            end
        endcase
    end

    // Outputs: the result is formed in the final cycle.
    always_comb begin
        rsp.done  = state_reg == tlics_pkg::IP_FIN;
        rsp.value = up ? (v0_reg + step) : (v0_reg - step);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tlics_pkg::IP_IDLE;
        end else begin
            state_reg <= state_next;
        end
        q_reg    <= q_next;
        rem_reg  <= rem_next;
        dv_reg   <= dv_next;
        cnt_reg  <= cnt_next;
        sat_reg  <= sat_next;
        v0_reg   <= v0_next;
        v1_reg   <= v1_next;
        prod_reg <= prod_next;
    end

endmodule

// File: sv/two_level_inverse_cdf_sampler.sv
// ----------------------------------------------------------------------------
// two_level_inverse_cdf_sampler
// Draws an energy and a zenith cosine from tabulated two-level CDFs.
// Each sample scans the cosine CDF and interpolates, then scans the energy CDF row of
// the chosen cosine bin and interpolates; a new transaction is accepted only once the
// last one is done. An interpolation whose fraction is zero or saturates skips the
// divider. Writes pass through the write state; fallback samples go straight to the output.
// Reset restores control and configuration; table RAMs hold undefined data until written.
// ----------------------------------------------------------------------------
module two_level_inverse_cdf_sampler #(
    parameter int COS_POINTS_MAX    = 128,
    parameter int ENERGY_POINTS_MAX = 256
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  tlics_pkg::in_item_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output tlics_pkg::out_item_t m_data,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_wdata
);

    localparam int CIW  = $clog2(COS_POINTS_MAX);
    localparam int EIW  = $clog2(ENERGY_POINTS_MAX);
    localparam int EDEP = COS_POINTS_MAX * ENERGY_POINTS_MAX;
    localparam int EAW  = $clog2(EDEP);
    localparam int KW   = (CIW > EIW) ? CIW : EIW;

    tlics_pkg::seq_state_t state_reg, state_next;

    // Configuration registers.
    logic [7:0]  cos_points_reg;
    logic [8:0]  energy_points_reg;
    logic        tables_ready_reg;
    logic [31:0] min_energy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cos_points_reg    <= tlics_pkg::COS_POINTS_RST;
            energy_points_reg <= tlics_pkg::ENERGY_POINTS_RST;
            tables_ready_reg  <= 1'b0;
            min_energy_reg    <= tlics_pkg::MIN_ENERGY_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                tlics_pkg::REG_COS_POINTS:    cos_points_reg    <= cfg_wdata[7:0];
                tlics_pkg::REG_ENERGY_POINTS: energy_points_reg <= cfg_wdata[8:0];
                tlics_pkg::REG_TABLES_READY:  tables_ready_reg  <= cfg_wdata[0];
                tlics_pkg::REG_MIN_ENERGY:    min_energy_reg    <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Last usable index of each table after clamping the point counts.
    logic [CIW-1:0] cos_last;
    logic [EIW-1:0] energy_last;

    always_comb begin
        if (cos_points_reg < 8'd2) begin
            cos_last = CIW'(1);
        end else if (int'(cos_points_reg) > COS_POINTS_MAX) begin
            cos_last = CIW'(COS_POINTS_MAX - 1);
        end else begin
            cos_last = CIW'(cos_points_reg - 8'd1);
        end
        if (energy_points_reg < 9'd2) begin
            energy_last = EIW'(1);
        end else if (int'(energy_points_reg) > ENERGY_POINTS_MAX) begin
            energy_last = EIW'(ENERGY_POINTS_MAX - 1);
        end else begin
            energy_last = EIW'(energy_points_reg - 9'd1);
        end
    end

    // Item and working registers.
    tlics_pkg::in_item_t item_reg, item_next;
    logic [KW-1:0]  k_reg, k_next;
    logic [KW-1:0]  idx_reg, idx_next;
    logic [EAW-1:0] row_reg, row_next;
    logic [32:0]    c0_reg, c0_next;
    logic [31:0]    g0_reg, g0_next;
    logic [16:0]    cos_val_reg, cos_val_next;
    logic [31:0]    e_val_reg, e_val_next;
    logic           fb_reg, fb_next;
    logic           m_valid_reg, m_valid_next;
    tlics_pkg::out_item_t m_data_reg, m_data_next;

    // Table RAM ports.
    logic           cos_we, egrid_we, ecdf_we;
    logic [CIW-1:0] cos_waddr, cos_raddr;
    logic [EIW-1:0] egrid_waddr, egrid_raddr;
    logic [EAW-1:0] ecdf_waddr, ecdf_raddr;
    logic [32:0]    cdf_sat;
    logic [16:0]    cgrid_sat;
    logic [32:0]    cos_cdf_rd, ecdf_rd;
    logic [16:0]    cos_grid_rd;
    logic [31:0]    egrid_rd;

    tlics_pkg::interp_req_t ireq;
    tlics_pkg::interp_rsp_t irsp;

    logic out_free;
    logic ci_ok, ei_ok;
    logic [KW-1:0] k_idx;

    assign s_ready  = state_reg == tlics_pkg::ST_IDLE;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign ci_ok    = int'(item_reg.cos_index) < COS_POINTS_MAX;
    assign ei_ok    = int'(item_reg.energy_index) < ENERGY_POINTS_MAX;
    // Step index of a finished scan: first match or the last usable entry, never below one.
    assign k_idx    = (k_reg == '0) ? KW'(1) : k_reg;

    // Write values saturated to the table ranges.
    assign cdf_sat   = (item_reg.cdf_value > tlics_pkg::ONE_Q32) ?
                       tlics_pkg::ONE_Q32 : item_reg.cdf_value;
    assign cgrid_sat = (item_reg.grid_value > {15'd0, tlics_pkg::ONE_Q16}) ?
                       tlics_pkg::ONE_Q16 : item_reg.grid_value[16:0];

    // Next state of the sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tlics_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (s_data.operation != tlics_pkg::OP_SAMPLE) begin
                        state_next = tlics_pkg::ST_WR;
                    end else if (!tables_ready_reg) begin
                        state_next = tlics_pkg::ST_OUT;
                    end else begin
                        state_next = tlics_pkg::ST_CS_ADDR;
                    end
                end
            end
            tlics_pkg::ST_WR:      state_next = tlics_pkg::ST_IDLE;
            tlics_pkg::ST_CS_ADDR: state_next = tlics_pkg::ST_CS_CMP;
            tlics_pkg::ST_CS_CMP: begin
                if ((cos_cdf_rd >= {1'b0, item_reg.rand_cos}) ||
                    (k_reg[CIW-1:0] == cos_last)) begin
                    state_next = tlics_pkg::ST_CL_ADDR;
                end else begin
                    state_next = tlics_pkg::ST_CS_ADDR;
                end
            end
            tlics_pkg::ST_CL_ADDR: state_next = tlics_pkg::ST_CH_ADDR;
            tlics_pkg::ST_CH_ADDR: state_next = tlics_pkg::ST_CH_DATA;
            tlics_pkg::ST_CH_DATA: state_next = tlics_pkg::ST_CI_WAIT;
            tlics_pkg::ST_CI_WAIT: begin
                if (irsp.done) begin
                    state_next = tlics_pkg::ST_ES_ADDR;
                end
            end
            tlics_pkg::ST_ES_ADDR: state_next = tlics_pkg::ST_ES_CMP;
            tlics_pkg::ST_ES_CMP: begin
                if ((ecdf_rd >= {1'b0, item_reg.rand_energy}) ||
                    (k_reg[EIW-1:0] == energy_last)) begin
                    state_next = tlics_pkg::ST_EL_ADDR;
                end else begin
                    state_next = tlics_pkg::ST_ES_ADDR;
                end
            end
            tlics_pkg::ST_EL_ADDR: state_next = tlics_pkg::ST_EH_ADDR;
            tlics_pkg::ST_EH_ADDR: state_next = tlics_pkg::ST_EH_DATA;
            tlics_pkg::ST_EH_DATA: state_next = tlics_pkg::ST_EI_WAIT;
            tlics_pkg::ST_EI_WAIT: begin
                if (irsp.done) begin
                    state_next = tlics_pkg::ST_OUT;
                end
            end
            tlics_pkg::ST_OUT: begin
                if (out_free) begin
                    state_next = tlics_pkg::ST_IDLE;
                end
            end
            default: state_next = tlics_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs: RAM ports and the interpolation request.
    always_comb begin
        cos_we      = 1'b0;
        egrid_we    = 1'b0;
        ecdf_we     = 1'b0;
        cos_waddr   = CIW'(item_reg.cos_index);
        egrid_waddr = EIW'(item_reg.energy_index);
        ecdf_waddr  = EAW'(item_reg.cos_index) * EAW'(ENERGY_POINTS_MAX) +
                      EAW'(item_reg.energy_index);
        cos_raddr   = k_reg[CIW-1:0];
        egrid_raddr = k_reg[EIW-1:0];
        ecdf_raddr  = row_reg + EAW'(k_reg);
        ireq.start  = 1'b0;
        ireq.c0     = c0_reg;
        ireq.c1     = cos_cdf_rd;
        ireq.v0     = g0_reg;
        ireq.v1     = {15'd0, cos_grid_rd};
        ireq.r      = item_reg.rand_cos;
        case (state_reg)
            tlics_pkg::ST_WR: begin
                cos_we   = (item_reg.operation == tlics_pkg::OP_WR_COS) && ci_ok;
                egrid_we = (item_reg.operation == tlics_pkg::OP_WR_EGRID) && ei_ok;
                ecdf_we  = (item_reg.operation == tlics_pkg::OP_WR_ECDF) &&
                           ci_ok && ei_ok;
            end
            tlics_pkg::ST_CL_ADDR: begin
                cos_raddr = CIW'(idx_reg - KW'(1));
            end
            tlics_pkg::ST_CH_ADDR: begin
                cos_raddr = idx_reg[CIW-1:0];
            end
            tlics_pkg::ST_CH_DATA: begin
                ireq.start = 1'b1;
            end
            tlics_pkg::ST_EL_ADDR: begin
                egrid_raddr = EIW'(idx_reg - KW'(1));
                ecdf_raddr  = row_reg + EAW'(idx_reg - KW'(1));
            end
            tlics_pkg::ST_EH_ADDR: begin
                egrid_raddr = idx_reg[EIW-1:0];
                ecdf_raddr  = row_reg + EAW'(idx_reg);
            end
            tlics_pkg::ST_EH_DATA: begin
                ireq.start = 1'b1;
                ireq.c1    = ecdf_rd;
                ireq.v1    = egrid_rd;
                ireq.r     = item_reg.rand_energy;
            end
            default: begin
            end
        endcase
    end

    // Working register updates.
    always_comb begin
        item_next    = item_reg;
        k_next       = k_reg;
        idx_next     = idx_reg;
        row_next     = row_reg;
        c0_next      = c0_reg;
        g0_next      = g0_reg;
        cos_val_next = cos_val_reg;
        e_val_next   = e_val_reg;
        fb_next      = fb_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            tlics_pkg::ST_IDLE: begin
                if (s_valid) begin
                    item_next  = s_data;
                    k_next     = '0;
                    fb_next    = !tables_ready_reg;
                    e_val_next = min_energy_reg;
                    cos_val_next = tlics_pkg::ONE_Q16;
                end
            end
            tlics_pkg::ST_CS_CMP: begin
                idx_next = k_idx;
                k_next   = k_reg + KW'(1);
            end
            tlics_pkg::ST_CL_ADDR: begin
                row_next = EAW'(idx_reg[CIW-1:0]) * EAW'(ENERGY_POINTS_MAX);
            end
            tlics_pkg::ST_CH_ADDR: begin
                c0_next = cos_cdf_rd;
                g0_next = {15'd0, cos_grid_rd};
            end
            tlics_pkg::ST_CI_WAIT: begin
                k_next = '0;
                if (irsp.done) begin
                    cos_val_next = irsp.value[16:0];
                end
            end
            tlics_pkg::ST_ES_CMP: begin
                idx_next = k_idx;
                k_next   = k_reg + KW'(1);
            end
            tlics_pkg::ST_EH_ADDR: begin
                c0_next = ecdf_rd;
                g0_next = egrid_rd;
            end
            tlics_pkg::ST_EI_WAIT: begin
                if (irsp.done) begin
                    e_val_next = irsp.value;
                end
            end
            tlics_pkg::ST_OUT: begin
                if (out_free) begin
                    m_valid_next          = 1'b1;
                    m_data_next.energy    = e_val_reg;
                    m_data_next.cos_theta = cos_val_reg;
                    m_data_next.fallback  = fb_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tlics_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        item_reg    <= item_next;
        k_reg       <= k_next;
        idx_reg     <= idx_next;
        row_reg     <= row_next;
        c0_reg      <= c0_next;
        g0_reg      <= g0_next;
        cos_val_reg <= cos_val_next;
        e_val_reg   <= e_val_next;
        fb_reg      <= fb_next;
        m_data_reg  <= m_data_next;
    end

    // Table memories.
    tlics_ram #(.WIDTH(33), .DEPTH(COS_POINTS_MAX)) u_cos_cdf (
        .aclk(aclk), .we(cos_we), .waddr(cos_waddr), .wdata(cdf_sat),
        .raddr(cos_raddr), .rdata(cos_cdf_rd)
    );

    tlics_ram #(.WIDTH(17), .DEPTH(COS_POINTS_MAX)) u_cos_grid (
        .aclk(aclk), .we(cos_we), .waddr(cos_waddr), .wdata(cgrid_sat),
        .raddr(cos_raddr), .rdata(cos_grid_rd)
    );

    tlics_ram #(.WIDTH(32), .DEPTH(ENERGY_POINTS_MAX)) u_energy_grid (
        .aclk(aclk), .we(egrid_we), .waddr(egrid_waddr),
        .wdata(item_reg.grid_value), .raddr(egrid_raddr), .rdata(egrid_rd)
    );

    tlics_ram #(.WIDTH(33), .DEPTH(EDEP)) u_energy_cdf (
        .aclk(aclk), .we(ecdf_we), .waddr(ecdf_waddr), .wdata(cdf_sat),
        .raddr(ecdf_raddr), .rdata(ecdf_rd)
    );

    // Shared interpolation unit.
    tlics_interp u_interp (
        .aclk(aclk), .aresetn(aresetn), .req(ireq), .rsp(irsp)
    );

    // The interpolation unit only finishes while the sequencer waits for it.
    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        irsp.done |-> (state_reg == tlics_pkg::ST_CI_WAIT ||
                       state_reg == tlics_pkg::ST_EI_WAIT))
        else $error("interpolation finished outside a wait state");

    // A cosine scan never runs past the last usable entry.
    a_cos_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tlics_pkg::ST_CS_CMP) |-> (k_reg[CIW-1:0] <= cos_last))
        else $error("cosine scan ran past the table end");

    // A finished sample waits while the previous result is still held.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tlics_pkg::ST_OUT && m_valid_reg && !m_ready)
        |=> (state_reg == tlics_pkg::ST_OUT))
        else $error("result register overwritten while stalled");

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-level inverse CDF sampler. A shadow copy of
// the tables and registers predicts each sample without a typed expectation;
// results are compared in order. A directed table runs first, then random traffic under several
// sender idle and receiver stall mixes.
// ----------------------------------------------------------------------------
module tb;

    localparam int NCOS = 128;
    localparam int NEN  = 256;
    // Loaded region: the last cosine entry and the last entry of every energy row
    // hold one, so no scan ever reaches past it.
    localparam int CB   = 16;
    localparam int EB   = 48;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    tlics_pkg::in_item_t  s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    tlics_pkg::out_item_t m_data;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = tlics_pkg::REG_COS_POINTS;
    logic [31:0] cfg_wdata = '0;

    // Shadow state of the block.
    logic [32:0] sh_cos_cdf [NCOS];
    logic [16:0] sh_cos_grid [NCOS];
    logic [31:0] sh_egrid [NEN];
    logic [32:0] sh_ecdf [NCOS*NEN];
    logic [7:0]  sh_cos_points = tlics_pkg::COS_POINTS_RST;
    logic [8:0]  sh_energy_points = tlics_pkg::ENERGY_POINTS_RST;
    logic        sh_tables_ready = 1'b0;
    logic [31:0] sh_min_energy = tlics_pkg::MIN_ENERGY_RST;

    tlics_pkg::out_item_t pending_samples [$];
    int        errors = 0;
    int        idle_pct = 0;
    int        stall_pct = 0;

    typedef struct {
        tlics_pkg::in_item_t  it;
        bit                   typed;
        tlics_pkg::out_item_t exp;
    } row_t;
    row_t rows [$];

    two_level_inverse_cdf_sampler u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always #6 aclk = ~aclk;

    // Receiver back-pressure.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    function automatic tlics_pkg::in_item_t mk(logic [1:0] op, logic [6:0] ci,
                                               logic [7:0] ei, logic [32:0] cdf,
                                               logic [31:0] grid,
                                               logic [31:0] rc, logic [31:0] re);
        tlics_pkg::in_item_t it;
        it.operation = op;
        it.cos_index = ci;
        it.energy_index = ei;
        it.cdf_value = cdf;
        it.grid_value = grid;
        it.rand_cos = rc;
        it.rand_energy = re;
        return it;
    endfunction

    // Linear interpolation between two grid points of one CDF step.
    function automatic logic [31:0] lerp(logic [32:0] c0, logic [32:0] c1,
                                         logic [31:0] v0, logic [31:0] v1,
                                         logic [31:0] r);
        logic [95:0] dv, alpha, mag, stp;
        dv = (c1 > c0) ? 96'(c1 - c0) : 96'(tlics_pkg::ONE_Q32);
        if ({1'b0, r} <= c0) begin
            alpha = '0;
        end else begin
            alpha = (96'({1'b0, r} - c0) << 32) / dv;
            if (alpha > 96'(tlics_pkg::ONE_Q32)) alpha = 96'(tlics_pkg::ONE_Q32);
        end
        mag = (v1 >= v0) ? 96'(v1 - v0) : 96'(v0 - v1);
        stp = (alpha * mag) >> 32;
        return (v1 >= v0) ? 32'(v0 + stp[31:0]) : 32'(v0 - stp[31:0]);
    endfunction

    // Applies one transaction to the shadow state; returns 1 with a sample.
    function automatic bit predict_sample(tlics_pkg::in_item_t it,
                                          output tlics_pkg::out_item_t res);
        logic [32:0] cdf;
        int nc, ne, i, j, base;
        logic [31:0] cosv;
        cdf = (it.cdf_value > tlics_pkg::ONE_Q32) ? tlics_pkg::ONE_Q32 : it.cdf_value;
        res = '0;
        case (it.operation)
            tlics_pkg::OP_WR_COS: begin
                sh_cos_cdf[it.cos_index] = cdf;
                sh_cos_grid[it.cos_index] = (it.grid_value > 32'(tlics_pkg::ONE_Q16)) ?
                                            tlics_pkg::ONE_Q16 : it.grid_value[16:0];
                return 0;
            end
            tlics_pkg::OP_WR_EGRID: begin
                sh_egrid[it.energy_index] = it.grid_value;
                return 0;
            end
            tlics_pkg::OP_WR_ECDF: begin
                sh_ecdf[it.cos_index * NEN + it.energy_index] = cdf;
                return 0;
            end
            default: begin
                if (!sh_tables_ready) begin
                    res.energy = sh_min_energy;
                    res.cos_theta = tlics_pkg::ONE_Q16;
                    res.fallback = 1'b1;
                    return 1;
                end
                nc = (sh_cos_points < 2) ? 2 : (sh_cos_points > NCOS) ? NCOS : sh_cos_points;
                ne = (sh_energy_points < 2) ? 2 :
                     (sh_energy_points > NEN) ? NEN : sh_energy_points;
                i = 0;
                while (i < nc && sh_cos_cdf[i] < {1'b0, it.rand_cos}) i++;
                if (i == 0) i = 1;
                if (i > nc - 1) i = nc - 1;
                cosv = lerp(sh_cos_cdf[i-1], sh_cos_cdf[i], 32'(sh_cos_grid[i-1]),
                            32'(sh_cos_grid[i]), it.rand_cos);
                base = i * NEN;
                j = 0;
                while (j < ne && sh_ecdf[base+j] < {1'b0, it.rand_energy}) j++;
                if (j == 0) j = 1;
                if (j > ne - 1) j = ne - 1;
                res.energy = lerp(sh_ecdf[base+j-1], sh_ecdf[base+j], sh_egrid[j-1],
                                  sh_egrid[j], it.rand_energy);
                res.cos_theta = cosv[16:0];
                res.fallback = 1'b0;
                return 1;
            end
        endcase
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("tb: mismatch %s got %h want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Result checker.
    always @(posedge aclk) begin
        tlics_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_samples.size() == 0) begin
                report("unexpected result", m_data.energy, '0);
            end else begin
                want = pending_samples.pop_front();
                if (m_data.energy !== want.energy)
                    report("energy", m_data.energy, want.energy);
                if (m_data.cos_theta !== want.cos_theta)
                    report("cos_theta", 32'(m_data.cos_theta), 32'(want.cos_theta));
                if (m_data.fallback !== want.fallback)
                    report("fallback", 32'(m_data.fallback), 32'(want.fallback));
            end
        end
    end

    // Drives one input transaction; a typed expectation overrides the predictor.
    task automatic send(tlics_pkg::in_item_t it, bit typed = 0,
                        tlics_pkg::out_item_t exp = '0);
        tlics_pkg::out_item_t res;
        @(negedge aclk);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        if (predict_sample(it, res)) pending_samples.push_back(typed ? exp : res);
    endtask

    // Lets every outstanding transaction finish.
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_samples.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            tlics_pkg::REG_COS_POINTS:    sh_cos_points = val[7:0];
            tlics_pkg::REG_ENERGY_POINTS: sh_energy_points = val[8:0];
            tlics_pkg::REG_TABLES_READY:  sh_tables_ready = val[0];
            default:                      sh_min_energy = val;
        endcase
    endtask

    // Next entry of a mostly rising CDF with occasional flat steps.
    function automatic logic [32:0] next_cdf(logic [32:0] c, int k, int last);
        logic [33:0] n;
        if (k == last) return tlics_pkg::ONE_Q32;
        if (k == 0 || $urandom_range(0, 7) == 0) return (k == 0) ? 33'd0 : c;
        n = 34'(c) + 34'($urandom_range(0, 32'h1000_0000));
        return (n > 34'(tlics_pkg::ONE_Q32)) ? tlics_pkg::ONE_Q32 : n[32:0];
    endfunction

    // Random sample fraction near a table entry, at an extreme, or anywhere.
    function automatic logic [31:0] pick_frac(logic [32:0] near);
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return near[31:0] + 32'($urandom_range(0, 2)) - 32'd1;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_items(int count);
        tlics_pkg::in_item_t it;
        int k;
        for (int n = 0; n < count; n++) begin
            k = $urandom_range(0, CB - 1);
            it = mk(2'($urandom_range(0, 3)), 7'($urandom_range(0, CB - 1)),
                    8'($urandom_range(0, EB - 1)),
                    {1'($urandom_range(0, 1)), 32'($urandom)}, $urandom, $urandom,
                    $urandom);
            if ($urandom_range(0, 99) < 75) begin
                it.operation = tlics_pkg::OP_SAMPLE;
                it.rand_cos = pick_frac(sh_cos_cdf[k]);
                it.rand_energy = pick_frac(sh_ecdf[k*NEN + $urandom_range(0, EB - 1)]);
            end else if ($urandom_range(0, 3) != 0 &&
                         it.operation != tlics_pkg::OP_WR_EGRID) begin
                // Mostly keep rewritten CDF entries between their neighbors.
                it.cdf_value = (it.operation == tlics_pkg::OP_WR_COS) ?
                               sh_cos_cdf[it.cos_index] :
                               sh_ecdf[it.cos_index * NEN + it.energy_index];
            end
            // The closing entry of each loaded table always stays at one.
            if ((it.operation == tlics_pkg::OP_WR_COS && it.cos_index == 7'(CB - 1)) ||
                (it.operation == tlics_pkg::OP_WR_ECDF &&
                 it.energy_index == 8'(EB - 1))) begin
                it.cdf_value = tlics_pkg::ONE_Q32;
            end
            send(it);
        end
    endtask

    initial begin
        logic [32:0] c;
        tlics_pkg::out_item_t fb;
        row_t r;

        // Reset.
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Samples before the tables are ready return the reset fallback.
        fb.energy = tlics_pkg::MIN_ENERGY_RST;
        fb.cos_theta = tlics_pkg::ONE_Q16;
        fb.fallback = 1'b1;
        rows = '{};
        r.typed = 1; r.exp = fb;
        r.it = mk(tlics_pkg::OP_SAMPLE, 7'd0, 8'd0, 33'd0, 32'd0, 32'd0, 32'd0);
        rows.push_back(r);
        r.it = mk(tlics_pkg::OP_SAMPLE, 7'h7F, 8'hFF, 33'h1_FFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF);
        rows.push_back(r);
        foreach (rows[n]) send(rows[n].it, rows[n].typed, rows[n].exp);

        // Load the table region in use; a flat cosine step sits at bins 9 and 10.
        c = '0;
        for (int k = 0; k < CB; k++) begin
            c = (k == 10) ? c : next_cdf(c, k, CB - 1);
            send(mk(tlics_pkg::OP_WR_COS, 7'(k), 8'd0, c,
                    32'((k * 517) + $urandom_range(0, 600)), 32'd0, 32'd0));
        end
        for (int k = 0; k < EB; k++) begin
            send(mk(tlics_pkg::OP_WR_EGRID, 7'd0, 8'(k), 33'd0, $urandom, 32'd0, 32'd0));
        end
        for (int b = 0; b < CB; b++) begin
            c = '0;
            for (int k = 0; k < EB; k++) begin
                c = next_cdf(c, k, EB - 1);
                send(mk(tlics_pkg::OP_WR_ECDF, 7'(b), 8'(k), c, 32'd0, 32'd0, 32'd0));
            end
        end
        drain();
        cfg_write(tlics_pkg::REG_COS_POINTS, 32'd128);
        cfg_write(tlics_pkg::REG_ENERGY_POINTS, 32'd256);
        cfg_write(tlics_pkg::REG_TABLES_READY, 32'd1);

        // Directed samples over the loaded tables, checked by the predictor.
        rows = '{};
        r.typed = 0;
        r.it = mk(tlics_pkg::OP_SAMPLE, 7'd0, 8'd0, 33'd0, 32'd0, 32'd0, 32'd0);
        rows.push_back(r);
        r.it = mk(tlics_pkg::OP_SAMPLE, 7'd0, 8'd0, 33'd0, 32'd0, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF);
        rows.push_back(r);
        r.it = mk(tlics_pkg::OP_SAMPLE, 7'd0, 8'd0, 33'd0, 32'd0, sh_cos_cdf[10][31:0],
                  32'h8000_0000);
        rows.push_back(r);
        r.it = mk(tlics_pkg::OP_SAMPLE, 7'd0, 8'd0, 33'd0, 32'd0,
                  sh_cos_cdf[9][31:0] + 32'd1, 32'd1);
        rows.push_back(r);
        r.it = mk(tlics_pkg::OP_SAMPLE, 7'd0, 8'd0, 33'd0, 32'd0, sh_cos_cdf[8][31:0],
                  sh_ecdf[8*NEN+20][31:0]);
        rows.push_back(r);
        // Oversized write values saturate.
        r.it = mk(tlics_pkg::OP_WR_COS, 7'(CB - 1), 8'd0, 33'h1_FFFF_FFFF, 32'hFFFF_FFFF,
                  32'd0, 32'd0);
        rows.push_back(r);
        r.it = mk(tlics_pkg::OP_WR_EGRID, 7'd0, 8'(EB - 1), 33'd0, 32'hFFFF_FFFF,
                  32'd0, 32'd0);
        rows.push_back(r);
        r.it = mk(tlics_pkg::OP_WR_ECDF, 7'(CB - 1), 8'(EB - 1), 33'h1_FFFF_FFFF, 32'd0,
                  32'd0, 32'd0);
        rows.push_back(r);
        r.it = mk(tlics_pkg::OP_SAMPLE, 7'd0, 8'd0, 33'd0, 32'd0, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF);
        rows.push_back(r);
        r.it = mk(tlics_pkg::OP_SAMPLE, 7'd0, 8'd0, 33'd0, 32'd0, 32'hFFFF_FFF0,
                  32'h0000_0010);
        rows.push_back(r);
        foreach (rows[n]) send(rows[n].it, rows[n].typed, rows[n].exp);

        // Random phases with different idle and stall mixes and settings.
        for (int p = 0; p < 4; p++) begin
            drain();
            case (p)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 85; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 85; end
                default: begin idle_pct = 30; stall_pct = 30; end
            endcase
            case (p)
                0: begin
                    cfg_write(tlics_pkg::REG_COS_POINTS, 2);
                    cfg_write(tlics_pkg::REG_ENERGY_POINTS, 2);
                end
                1: begin
                    cfg_write(tlics_pkg::REG_COS_POINTS, 255);
                    cfg_write(tlics_pkg::REG_ENERGY_POINTS, 511);
                end
                2: begin
                    cfg_write(tlics_pkg::REG_COS_POINTS, $urandom_range(2, 128));
                    cfg_write(tlics_pkg::REG_ENERGY_POINTS, $urandom_range(2, 256));
                end
                default: begin
                    cfg_write(tlics_pkg::REG_COS_POINTS, 0);
                    cfg_write(tlics_pkg::REG_ENERGY_POINTS, 1);
                end
            endcase
            // A short stretch with the tables marked not ready.
            cfg_write(tlics_pkg::REG_TABLES_READY, 0);
            cfg_write(tlics_pkg::REG_MIN_ENERGY,
                      (p == 0) ? 32'd0 : (p == 1) ? 32'hFFFF_FFFF : $urandom);
            random_items(25);
            drain();
            cfg_write(tlics_pkg::REG_TABLES_READY, 1);
            random_items(100);
            if (p == 1) drain();
            random_items(100);
        end

        drain();
        repeat (1000) @(negedge aclk);
        if (errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

    // Run limit.
    initial begin
        #400ms;
        $display("tb: done, errors");
        $finish;
    end

endmodule
